// ===== rtl/ile_pkg.sv =====
package ile_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam int CMD_W   = 3;
    localparam int POS_W   = 7;
    localparam int VAL_W   = 32;
    localparam int STAT_W  = 2;
    localparam int LEN_W   = 7;

    localparam int IN_BITS   = CMD_W + POS_W + VAL_W;
    localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = VAL_W + STAT_W + LEN_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ   = 3'd0,
        CMD_FRONT  = 3'd1,
        CMD_BACK   = 3'd2,
        CMD_AT     = 3'd3,
        CMD_DELETE = 3'd4
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RD_WAIT,
        S_INS_STEP,
        S_INS_WR,
        S_DEL_STEP,
        S_DEL_WR,
        S_DONE
    } state_t;

    localparam logic [VAL_W-1:0] READ_MISS = {VAL_W{1'b1}};

endpackage

// ===== rtl/indexed_list_engine.sv =====
// Indexed list engine: an ordered list of signed 32-bit values held in a
// single-port-write, single-port-read memory of CAPACITY words.
// Input word (s_*): command, position, value. Output word (m_*): read value,
// status and the list length after the command. Every input word yields
// exactly one output word.
// One command is worked at a time; s_tready is high only while the block is
// idle. A read goes through the memory (memory read data is registered); an
// insert (any kind) moves length - index entries up, a delete moves
// length - index - 1 entries down; refused or unknown commands touch no
// memory. Each moved entry costs one memory read and one memory write.
// Reset empties the list (length zero); the memory itself is not cleared.
// When the receiver stalls, the finished word holds in the output register
// and the sequencer waits in its final state until the register frees.
module indexed_list_engine
#(
    parameter int CAPACITY = ile_pkg::CAPACITY_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [2:0] command, [9:3] position, [41:10] value, [47:42] zero
    input  logic [ile_pkg::IN_DATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [31:0] read_value, [33:32] status, [40:34] length, [47:41] zero
    output logic [ile_pkg::OUT_DATA_W-1:0]  m_tdata
);
    import ile_pkg::*;

    localparam int AW    = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    logic [VAL_W-1:0] entry_mem [CAPACITY];
    logic [VAL_W-1:0] rdata_reg;

    state_t state_reg, state_next;

    cmd_t               cmd_reg,   cmd_next;
    logic [POS_W-1:0]   pos_reg,   pos_next;
    logic [VAL_W-1:0]   val_reg,   val_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   ptr_reg,   ptr_next;
    logic [CNT_W-1:0]   at_reg,    at_next;
    logic [VAL_W-1:0]   res_val_reg, res_val_next;
    status_t            res_st_reg,  res_st_next;
    logic               m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;

    logic             mem_re, mem_we;
    logic [AW-1:0]    rd_addr, wr_addr;
    logic [VAL_W-1:0] wr_data;

    logic [CMP_W-1:0] pos_ext, cnt_ext, cap_ext;
    logic [CNT_W-1:0] ptr_dec, ptr_inc;
    logic             out_free;

    assign pos_ext  = CMP_W'(pos_reg);
    assign cnt_ext  = CMP_W'(count_reg);
    assign cap_ext  = CMP_W'(CAPACITY);
    assign ptr_dec  = ptr_reg - CNT_W'(1);
    assign ptr_inc  = ptr_reg + CNT_W'(1);
    assign out_free = !m_valid_reg || m_tready;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                case (cmd_reg) inside
                    CMD_READ:
                    begin
                        if (pos_ext < cnt_ext)
                            state_next = S_RD_WAIT;
                        else
                            state_next = S_DONE;
                    end
                    CMD_FRONT, CMD_BACK:
                    begin
                        if (cnt_ext == cap_ext)
                            state_next = S_DONE;
                        else
                            state_next = S_INS_STEP;
                    end
                    CMD_AT:
                    begin
                        if (pos_ext > cnt_ext || cnt_ext == cap_ext)
                            state_next = S_DONE;
                        else
                            state_next = S_INS_STEP;
                    end
                    CMD_DELETE:
                    begin
                        if (pos_ext >= cnt_ext)
                            state_next = S_DONE;
                        else
                            state_next = S_DEL_STEP;
                    end
                    default:
                        state_next = S_DONE;
                endcase
            end
            S_RD_WAIT:
                state_next = S_DONE;
            S_INS_STEP:
            begin
                if (ptr_reg > at_reg)
                    state_next = S_INS_WR;
                else
                    state_next = S_DONE;
            end
            S_INS_WR:
                state_next = S_INS_STEP;
            S_DEL_STEP:
            begin
                if (ptr_inc < count_reg)
                    state_next = S_DEL_WR;
                else
                    state_next = S_DONE;
            end
            S_DEL_WR:
                state_next = S_DEL_STEP;
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Datapath control
    always_comb
    begin
        cmd_next     = cmd_reg;
        pos_next     = pos_reg;
        val_next     = val_reg;
        count_next   = count_reg;
        ptr_next     = ptr_reg;
        at_next      = at_reg;
        res_val_next = res_val_reg;
        res_st_next  = res_st_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        mem_re       = 1'b0;
        mem_we       = 1'b0;
        rd_addr      = ptr_reg[AW-1:0];
        wr_addr      = ptr_reg[AW-1:0];
        wr_data      = rdata_reg;

        if (m_valid_reg && m_tready)
            m_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next     = cmd_t'(s_tdata[CMD_W-1:0]);
                    pos_next     = s_tdata[CMD_W +: POS_W];
                    val_next     = s_tdata[CMD_W + POS_W +: VAL_W];
                    res_val_next = '0;
                    res_st_next  = ST_DONE;
                end
            end
            S_EXEC:
            begin
                ptr_next = count_reg;
                case (cmd_reg)
                    CMD_READ:
                    begin
                        if (pos_ext < cnt_ext)
                        begin
                            mem_re  = 1'b1;
                            rd_addr = pos_ext[AW-1:0];
                        end
                        else
                        begin
                            res_val_next = READ_MISS;
                            res_st_next  = ST_RANGE;
                        end
                    end
                    CMD_FRONT:
                    begin
                        at_next = '0;
                        if (cnt_ext == cap_ext)
                            res_st_next = ST_FULL;
                    end
                    CMD_BACK:
                    begin
                        at_next = count_reg;
                        if (cnt_ext == cap_ext)
                            res_st_next = ST_FULL;
                    end
                    CMD_AT:
                    begin
                        at_next = pos_ext[CNT_W-1:0];
                        // range check wins over the full check
                        if (pos_ext > cnt_ext)
                            res_st_next = ST_RANGE;
                        else if (cnt_ext == cap_ext)
                            res_st_next = ST_FULL;
                    end
                    CMD_DELETE:
                    begin
                        ptr_next = pos_ext[CNT_W-1:0];
                        if (pos_ext >= cnt_ext)
                            res_st_next = ST_RANGE;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_RD_WAIT:
                res_val_next = rdata_reg;
            S_INS_STEP:
            begin
                if (ptr_reg > at_reg)
                begin
                    mem_re  = 1'b1;
                    rd_addr = ptr_dec[AW-1:0];
                end
                else
                begin
                    // gap is open: drop the new value in
                    mem_we     = 1'b1;
                    wr_addr    = at_reg[AW-1:0];
                    wr_data    = val_reg;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            S_INS_WR:
            begin
                mem_we   = 1'b1;
                ptr_next = ptr_dec;
            end
            S_DEL_STEP:
            begin
                if (ptr_inc < count_reg)
                begin
                    mem_re  = 1'b1;
                    rd_addr = ptr_inc[AW-1:0];
                end
                else
                    count_next = count_reg - CNT_W'(1);
            end
            S_DEL_WR:
            begin
                mem_we   = 1'b1;
                ptr_next = ptr_inc;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = OUT_DATA_W'({cnt_ext[LEN_W-1:0], res_st_reg, res_val_reg});
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            entry_mem[wr_addr] <= wr_data;
        if (mem_re)
            rdata_reg <= entry_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        pos_reg     <= pos_next;
        val_reg     <= val_next;
        ptr_reg     <= ptr_next;
        at_reg      <= at_next;
        res_val_reg <= res_val_next;
        res_st_reg  <= res_st_next;
        m_data_reg  <= m_data_next;
    end

endmodule

// ===== dv/indexed_list_monitor.sv =====
`timescale 1ns / 1ps

module indexed_list_monitor
#(
    parameter int CAPACITY = ile_pkg::CAPACITY_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    // [2:0] command, [9:3] position, [41:10] value, [47:42] zero
    input  logic [ile_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    // [31:0] read_value, [33:32] status, [40:34] length, [47:41] zero
    input  logic [ile_pkg::OUT_DATA_W-1:0] m_tdata,
    output int                             mismatch_count,
    output int                             results_due
);
    import ile_pkg::*;

    typedef struct packed {
        logic [VAL_W-1:0] read_value;
        status_t          status;
        logic [LEN_W-1:0] length;
    } list_result_t;

    logic [VAL_W-1:0] list_words [CAPACITY];
    int               list_len;
    list_result_t     due_results [$];

    function automatic list_result_t apply_list_command(input cmd_t cmd, input int pos,
                                                        input logic [VAL_W-1:0] val);
        list_result_t res;
        int           at;
        res.read_value = '0;
        res.status     = ST_DONE;
        at             = pos;
        case (cmd) inside
            CMD_READ:
            begin
                if (pos < list_len)
                begin
                    res.read_value = list_words[pos];
                end
                else
                begin
                    res.read_value = READ_MISS;
                    res.status     = ST_RANGE;
                end
            end
            CMD_FRONT, CMD_BACK, CMD_AT:
            begin
                if (cmd == CMD_FRONT)
                    at = 0;
                else if (cmd == CMD_BACK)
                    at = list_len;
                // range is checked ahead of capacity
                if (at > list_len)
                begin
                    res.status = ST_RANGE;
                end
                else if (list_len >= CAPACITY)
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    for (int i = list_len; i > at; i--)
                        list_words[i] = list_words[i - 1];
                    list_words[at] = val;
                    list_len++;
                end
            end
            CMD_DELETE:
            begin
                if (pos >= list_len)
                begin
                    res.status = ST_RANGE;
                end
                else
                begin
                    for (int i = pos; i + 1 < list_len; i++)
                        list_words[i] = list_words[i + 1];
                    list_len--;
                end
            end
            default:
            begin
            end
        endcase
        res.length = list_len[LEN_W-1:0];
        return res;
    endfunction

    task automatic compare_field(input string field_name, input logic [VAL_W-1:0] want,
                                 input logic [VAL_W-1:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch: expected %h, actual %h",
                     $time, field_name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        list_result_t want;
        if (!rst_n)
        begin
            mismatch_count = 0;
            list_len       = 0;
            due_results.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (due_results.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected word: expected none, actual %h",
                             $time, m_tdata);
                end
                else
                begin
                    want = due_results.pop_front();
                    compare_field("read_value", want.read_value, m_tdata[VAL_W-1:0]);
                    compare_field("status", VAL_W'(want.status), VAL_W'(m_tdata[VAL_W +: STAT_W]));
                    compare_field("length", VAL_W'(want.length),
                                  VAL_W'(m_tdata[VAL_W+STAT_W +: LEN_W]));
                    compare_field("padding", '0, VAL_W'(m_tdata[OUT_DATA_W-1:OUT_BITS]));
                end
            end
            if (s_tvalid && s_tready)
                due_results.push_back(apply_list_command(cmd_t'(s_tdata[CMD_W-1:0]),
                                                         int'(s_tdata[CMD_W +: POS_W]),
                                                         s_tdata[CMD_W+POS_W +: VAL_W]));
        end
        results_due = due_results.size();
    end

endmodule

// ===== dv/tb_indexed_list_engine.sv =====
`timescale 1ns / 1ps

module tb_indexed_list_engine;

    import ile_pkg::*;

    localparam int WORD_TARGET  = 1550;
    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 150;
    localparam int POS_MAX      = (1 << POS_W) - 1;

    localparam logic [CMD_W-1:0] FIRST_UNUSED_CMD = 3'd5;
    localparam logic [CMD_W-1:0] LAST_UNUSED_CMD  = 3'd7;

    typedef enum {PH_FILL, PH_DRAIN, PH_MIXED} phase_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    int mismatch_count;
    int results_due;
    int words_sent  = 0;
    int fill        = 0;
    int burst_left  = 1;
    int quiet_cycles = 0;

    logic [15:0] stall_pattern = 16'hFFFF;
    int          pattern_age   = 0;

    always #1 clk = ~clk;

    indexed_list_engine dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    indexed_list_monitor monitor (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .results_due    (results_due)
    );

    // receiver: rotate a stall pattern, reload it whenever pattern_age wraps
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (pattern_age == 63)
            begin
                pattern_age <= 0;
                case ($urandom_range(0, 3))
                    0: stall_pattern <= 16'hFFFF;
                    1: stall_pattern <= 16'($urandom) | 16'h0001;
                    2: stall_pattern <= 16'($urandom & $urandom) | 16'h0100;
                    default: stall_pattern <= 16'($urandom) | 16'h8421;
                endcase
            end
            else
            begin
                pattern_age   <= pattern_age + 1;
                stall_pattern <= {stall_pattern[14:0], stall_pattern[15]};
            end
            m_tready <= stall_pattern[15];
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // hold the word until accepted, track the list fill, then maybe gap
    task automatic issue_word(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                              input logic [VAL_W-1:0] val);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_DATA_W-IN_BITS){1'b0}}, val, pos, cmd};
        do
            @(posedge clk);
        while (!s_tready);
        words_sent++;
        case (cmd) inside
            CMD_FRONT, CMD_BACK:
                if (fill < CAPACITY_DEF)
                    fill++;
            CMD_AT:
                if (pos <= fill && fill < CAPACITY_DEF)
                    fill++;
            CMD_DELETE:
                if (pos < fill)
                    fill--;
            default:
            begin
            end
        endcase
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 12);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    endtask

    initial
    begin
        phase_t           phase;
        int               phase_left;
        int               ins_pct;
        int               del_pct;
        int               rd_pct;
        int               roll;
        logic [CMD_W-1:0] cmd;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list, then build a short list of extreme values
        issue_word(CMD_READ, 0, 0);
        issue_word(CMD_DELETE, 0, 0);
        issue_word(CMD_AT, 1, $urandom);
        issue_word(CMD_AT, 0, 32'h8000_0000);
        issue_word(CMD_FRONT, 7'h7F, 32'h7FFF_FFFF);
        issue_word(CMD_BACK, 7'h55, 32'hFFFF_FFFF);
        issue_word(CMD_AT, 1, 32'h0000_0000);
        issue_word(CMD_AT, 4, 32'hA5A5_5A5A);
        for (int i = 0; i < 6; i++)
            issue_word(CMD_READ, POS_W'(i), $urandom);
        issue_word(CMD_READ, 7'h7F, 0);
        issue_word(CMD_DELETE, 7'h7F, 0);
        issue_word(CMD_AT, 7'h7F, 32'h1234_5678);
        issue_word(FIRST_UNUSED_CMD, 2, $urandom);
        issue_word(FIRST_UNUSED_CMD + 3'd1, 7'h40, $urandom);
        issue_word(LAST_UNUSED_CMD, 7'h7F, 32'hFFFF_FFFF);
        issue_word(CMD_DELETE, 4, 0);
        issue_word(CMD_DELETE, 0, 0);
        issue_word(CMD_DELETE, 1, 0);
        issue_word(CMD_READ, 0, 0);
        issue_word(CMD_READ, 1, 0);

        while (words_sent < WORD_TARGET)
        begin
            phase      = phase_t'($urandom_range(0, 2));
            phase_left = $urandom_range(10, 120);
            case (phase)
                PH_FILL:
                begin
                    ins_pct = 80;
                    del_pct = 7;
                    rd_pct  = 10;
                end
                PH_DRAIN:
                begin
                    ins_pct = 15;
                    del_pct = 62;
                    rd_pct  = 20;
                end
                default:
                begin
                    ins_pct = 40;
                    del_pct = 35;
                    rd_pct  = 22;
                end
            endcase
            while (phase_left > 0 && words_sent < WORD_TARGET)
            begin
                phase_left--;
                roll = $urandom_range(0, 99);
                if (roll < ins_pct)
                begin
                    case ($urandom_range(0, 2))
                        0: cmd = CMD_FRONT;
                        1: cmd = CMD_BACK;
                        default: cmd = CMD_AT;
                    endcase
                end
                else if (roll < ins_pct + del_pct)
                    cmd = CMD_DELETE;
                else if (roll < ins_pct + del_pct + rd_pct)
                    cmd = CMD_READ;
                else
                    cmd = CMD_W'($urandom_range(FIRST_UNUSED_CMD, LAST_UNUSED_CMD));

                // aim mostly inside the list, sometimes at its edges or anywhere
                roll = $urandom_range(0, 99);
                if (roll < 8)
                begin
                    pos = POS_W'($urandom_range(0, POS_MAX));
                end
                else if (roll < 18)
                begin
                    case ($urandom_range(0, 3))
                        0: pos = 0;
                        1: pos = POS_W'((fill == 0) ? 0 : fill - 1);
                        2: pos = POS_W'(fill);
                        default: pos = POS_W'(fill + 1);
                    endcase
                end
                else if (cmd == CMD_AT)
                    pos = POS_W'($urandom_range(0, fill));
                else
                    pos = POS_W'((fill == 0) ? 0 : $urandom_range(0, fill - 1));

                if ($urandom_range(0, 9) == 0)
                begin
                    case ($urandom_range(0, 3))
                        0: val = 32'h8000_0000;
                        1: val = 32'h7FFF_FFFF;
                        2: val = 32'h0000_0000;
                        default: val = 32'hFFFF_FFFF;
                    endcase
                end
                else
                    val = $urandom;

                issue_word(cmd, pos, val);
            end
        end
        if (s_tvalid)
            s_tvalid <= 1'b0;

        @(negedge clk);
        while (results_due != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        if (mismatch_count == 0 && results_due == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/ile_pkg.sv
rtl/indexed_list_engine.sv
dv/indexed_list_monitor.sv
dv/tb_indexed_list_engine.sv
